// ===== rtl/rtpdtmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpdtmf_pkg
// Types and constants shared by the telephone-event receiver modules.
// ----------------------------------------------------------------------------
package rtpdtmf_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_EVENT_PT = 2'd0,
      CSR_ALT_PT   = 2'd1,
      CSR_KEY_DOWN = 2'd2
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [6:0] EVENT_PT_RESET = 7'd101;
   localparam logic [6:0] ALT_PT_RESET   = 7'd101;

   // volume above this counts as too quiet
   localparam logic [5:0] QUIET_LIMIT = 6'd55;

   // one delivered event
   typedef struct packed {
      logic [7:0]  digit;
      logic [5:0]  level;
      logic [31:0] duration;
   } token_type;

   // classified packet handed from the front to the back
   typedef struct packed {
      logic      handled;
      logic      old_valid;
      token_type old_tok;
      logic      new_valid;
      token_type new_tok;
   } cmd_type;

endpackage

// ===== rtl/rtpdtmf_front.sv =====
// ----------------------------------------------------------------------------
// rtpdtmf_front
// Accepts packets, matches payload type, filters quiet events, tracks the
// current event and emits one classified command per packet.
// ----------------------------------------------------------------------------
module rtpdtmf_front import rtpdtmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_push,
   input  logic [6:0]  req_payload_type,
   input  logic [31:0] req_rtp_timestamp,
   input  logic [15:0] req_event_word,
   input  logic [15:0] req_duration_word,
   input  logic        q_full,
   output logic        cmd_push,
   output cmd_type     cmd
);

   logic [6:0]  event_pt_ff, event_pt_in;
   logic [6:0]  alt_pt_ff, alt_pt_in;
   logic        key_down_ff, key_down_in;

   logic        have_event_ff, have_event_in;
   logic [7:0]  digit_ff, digit_in;
   logic [5:0]  level_ff, level_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [31:0] dur_ff, dur_in;
   logic        delivered_ff, delivered_in;

   logic [7:0]  pkt_digit;
   logic [5:0]  pkt_vol;
   logic        pkt_end;
   logic        pt_match;
   logic        live;
   logic        is_new;
   logic        release_evt;
   logic [32:0] sum;
   logic [31:0] sat_dur;

   // field extraction
   assign pkt_digit = req_event_word[15:8];
   assign pkt_vol   = req_event_word[5:0];
   assign pkt_end   = req_event_word[7];

   assign cmd_push    = req_push && !q_full;
   assign pt_match    = (req_payload_type == event_pt_ff) ||
                        (req_payload_type == alt_pt_ff);
   assign live        = cmd_push && pt_match && (pkt_vol <= QUIET_LIMIT);
   assign is_new      = !have_event_ff || (digit_ff != pkt_digit) ||
                        (stamp_ff != req_rtp_timestamp);
   assign release_evt = key_down_ff || pkt_end;

   // saturating duration accumulate
   assign sum     = {1'b0, dur_ff} + {17'd0, req_duration_word};
   assign sat_dur = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

   // command to the back end
   always_comb begin
      cmd.handled          = pt_match;
      cmd.old_valid        = live && is_new && have_event_ff && !delivered_ff;
      cmd.old_tok.digit    = digit_ff;
      cmd.old_tok.level    = level_ff;
      cmd.old_tok.duration = dur_ff;
      cmd.new_valid        = live && release_evt && (is_new || !delivered_ff);
      if (is_new) begin
         cmd.new_tok.digit    = pkt_digit;
         cmd.new_tok.level    = pkt_vol;
         cmd.new_tok.duration = {16'd0, req_duration_word};
      end else begin
         cmd.new_tok.digit    = digit_ff;
         cmd.new_tok.level    = level_ff;
         cmd.new_tok.duration = sat_dur;
      end
   end

   // configuration writes
   always_comb begin
      event_pt_in = event_pt_ff;
      alt_pt_in   = alt_pt_ff;
      key_down_in = key_down_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_EVENT_PT: event_pt_in = csr_wdata;
            CSR_ALT_PT:   alt_pt_in   = csr_wdata;
            CSR_KEY_DOWN: key_down_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // event tracking
   always_comb begin
      have_event_in = have_event_ff;
      digit_in      = digit_ff;
      level_in      = level_ff;
      stamp_in      = stamp_ff;
      dur_in        = dur_ff;
      delivered_in  = delivered_ff;
      if (live) begin
         if (is_new) begin
            have_event_in = 1'b1;
            digit_in      = pkt_digit;
            level_in      = pkt_vol;
            stamp_in      = req_rtp_timestamp;
            dur_in        = {16'd0, req_duration_word};
            delivered_in  = release_evt;
         end else if (!delivered_ff) begin
            dur_in = sat_dur;
            if (release_evt) begin
               delivered_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_pt_ff   <= EVENT_PT_RESET;
         alt_pt_ff     <= ALT_PT_RESET;
         key_down_ff   <= 1'b0;
         have_event_ff <= 1'b0;
         digit_ff      <= '0;
         level_ff      <= '0;
         stamp_ff      <= '0;
         dur_ff        <= '0;
         delivered_ff  <= 1'b0;
      end else begin
         event_pt_ff   <= event_pt_in;
         alt_pt_ff     <= alt_pt_in;
         key_down_ff   <= key_down_in;
         have_event_ff <= have_event_in;
         digit_ff      <= digit_in;
         level_ff      <= level_in;
         stamp_ff      <= stamp_in;
         dur_ff        <= dur_in;
         delivered_ff  <= delivered_in;
      end
   end

`ifndef SYNTHESIS
   // any token implies a matched payload type
   a_token_handled: assert property (@(posedge clock) disable iff (reset)
      cmd_push && (cmd.old_valid || cmd.new_valid) |-> cmd.handled)
      else $error("token emitted for foreign payload type");
   // a flush only happens when an event was held
   a_flush_needs_event: assert property (@(posedge clock) disable iff (reset)
      cmd_push && cmd.old_valid |-> have_event_ff && !delivered_ff)
      else $error("flush without a pending event");
`endif

endmodule

// ===== rtl/rtpdtmf_queue.sv =====
// ----------------------------------------------------------------------------
// rtpdtmf_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module rtpdtmf_queue import rtpdtmf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue fill count out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");
`endif

endmodule

// ===== rtl/rtpdtmf_back.sv =====
// ----------------------------------------------------------------------------
// rtpdtmf_back
// Expands each command into one or two result beats held in an output
// register.
// ----------------------------------------------------------------------------
module rtpdtmf_back import rtpdtmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  cmd_type     head,
   output logic        q_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic        rsp_handled,
   output logic        rsp_token_valid,
   output logic [7:0]  rsp_digit,
   output logic [5:0]  rsp_level,
   output logic [31:0] rsp_total_duration,
   output logic        rsp_last
);

   logic        out_valid_ff, out_valid_in;
   logic        phase_ff, phase_in;
   logic        load;
   logic        step;
   logic        beat_tok;
   token_type   beat;
   logic        beat_last;
   logic        beat_done;

   logic        handled_ff;
   logic        tok_ff;
   token_type   tok_data_ff;
   logic        last_ff;

   assign load  = !out_valid_ff || rsp_pop;
   assign step  = load && !q_empty;
   assign q_pop = step && beat_done;

   // choose the next beat from the head command
   always_comb begin
      beat_tok  = 1'b0;
      beat      = '0;
      beat_last = 1'b1;
      beat_done = 1'b1;
      phase_in  = phase_ff;
      if (!phase_ff && head.old_valid) begin
         beat_tok  = 1'b1;
         beat      = head.old_tok;
         beat_last = !head.new_valid;
         beat_done = !head.new_valid;
         if (step) begin
            phase_in = head.new_valid;
         end
      end else begin
         if (head.new_valid) begin
            beat_tok = 1'b1;
            beat     = head.new_tok;
         end
         if (step) begin
            phase_in = 1'b0;
         end
      end
      out_valid_in = load ? !q_empty : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   // output register, no reset
   always_ff @(posedge clock) begin
      if (step) begin
         handled_ff  <= head.handled;
         tok_ff      <= beat_tok;
         tok_data_ff <= beat;
         last_ff     <= beat_last;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_handled        = handled_ff;
   assign rsp_token_valid    = tok_ff;
   assign rsp_digit          = tok_data_ff.digit;
   assign rsp_level          = tok_data_ff.level;
   assign rsp_total_duration = tok_data_ff.duration;
   assign rsp_last           = last_ff;

`ifndef SYNTHESIS
   // second half of a two-token packet keeps its command at the head
   a_phase_has_cmd: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !q_empty)
      else $error("second token pending with empty queue");
   // mid-packet beat is always followed by its last beat
   a_phase_after_first: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> out_valid_ff && !last_ff)
      else $error("second token pending without first beat shown");
`endif

endmodule

// ===== rtl/rtp_dtmf_event_receiver_core.sv =====
// Path: an accepted packet is written into the command queue and then loaded into
// the result output register, when that is empty or popped, to show its first beat.
// Throughput: one packet per cycle when it yields one beat and results are popped;
// a flush plus a new event gives two beats through the single result register.
// Reset: synchronous, active high; clears event state, empties queue and output
// register, and loads payload types 101 and key-down delivery off.
// ----------------------------------------------------------------------------
// rtp_dtmf_event_receiver_core
// Telephone-event receiver: front classifier, command queue and result back end.
// ----------------------------------------------------------------------------
module rtp_dtmf_event_receiver_core import rtpdtmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic [6:0]  req_payload_type,
   input  logic [31:0] req_rtp_timestamp,
   input  logic [15:0] req_event_word,
   input  logic [15:0] req_duration_word,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_handled,
   output logic        rsp_token_valid,
   output logic [7:0]  rsp_digit,
   output logic [5:0]  rsp_level,
   output logic [31:0] rsp_total_duration,
   output logic        rsp_last
);

   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type head;

   assign req_full = q_full;

   rtpdtmf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_push          (req_push),
      .req_payload_type  (req_payload_type),
      .req_rtp_timestamp (req_rtp_timestamp),
      .req_event_word    (req_event_word),
      .req_duration_word (req_duration_word),
      .q_full            (q_full),
      .cmd_push          (cmd_push),
      .cmd               (cmd)
   );

   rtpdtmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   rtpdtmf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .head               (head),
      .q_pop              (q_pop),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_handled        (rsp_handled),
      .rsp_token_valid    (rsp_token_valid),
      .rsp_digit          (rsp_digit),
      .rsp_level          (rsp_level),
      .rsp_total_duration (rsp_total_duration),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== dv/rtp_dtmf_event_checker.sv =====
// ----------------------------------------------------------------------------
// rtp_dtmf_event_checker
// Watches the packet, result and register ports of the telephone-event
// receiver. It keeps its own copy of the registers and the held event, works
// out the result beats that each accepted packet must produce, and compares
// every popped beat, field by field, with the oldest beat still due.
// ----------------------------------------------------------------------------
module rtp_dtmf_event_checker import rtpdtmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [6:0]  req_payload_type,
   input  logic [31:0] req_rtp_timestamp,
   input  logic [15:0] req_event_word,
   input  logic [15:0] req_duration_word,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_handled,
   input  logic        rsp_token_valid,
   input  logic [7:0]  rsp_digit,
   input  logic [5:0]  rsp_level,
   input  logic [31:0] rsp_total_duration,
   input  logic        rsp_last,
   output int          fail_count,
   output int          beats_due,
   output int          beats_checked,
   output int          tokens_checked
);

   // one result beat as the block presents it
   typedef struct packed {
      logic        handled;
      logic        token_valid;
      logic [7:0]  digit;
      logic [5:0]  level;
      logic [31:0] total_duration;
      logic        last;
   } dtmf_beat_type;

   // register copy
   logic [6:0]  event_pt;
   logic [6:0]  alt_pt;
   logic        key_down_mode;

   // held event
   logic        have_event;
   logic [7:0]  held_digit;
   logic [5:0]  held_level;
   logic [31:0] held_stamp;
   logic [31:0] held_duration;
   logic        delivered;

   dtmf_beat_type beats_q[$];
   int            errors;
   int            checked;
   int            tokens;

   // token beat built from the held event
   function automatic dtmf_beat_type held_token();
      dtmf_beat_type b;
      b.handled        = 1'b1;
      b.token_valid    = 1'b1;
      b.digit          = held_digit;
      b.level          = held_level;
      b.total_duration = held_duration;
      b.last           = 1'b0;
      return b;
   endfunction

   // classify one packet, update the held event, queue the beats it yields
   task automatic predict_packet(input logic [6:0] pt, input logic [31:0] stamp,
                                 input logic [15:0] ew, input logic [15:0] dw);
      dtmf_beat_type made[2];
      dtmf_beat_type none;
      int          n;
      int          i;
      logic        matched;
      logic        send_now;
      logic [32:0] sum;
      n        = 0;
      matched  = (pt == event_pt) || (pt == alt_pt);
      send_now = key_down_mode || ew[7];
      if (matched && ew[5:0] <= QUIET_LIMIT) begin
         if (!have_event || held_digit != ew[15:8] || held_stamp != stamp) begin
            // new event: flush an undelivered old one first
            if (have_event && !delivered) begin
               made[n] = held_token();
               n++;
            end
            have_event    = 1'b1;
            held_digit    = ew[15:8];
            held_level    = ew[5:0];
            held_stamp    = stamp;
            held_duration = {16'h0000, dw};
            if (send_now) begin
               made[n] = held_token();
               n++;
            end
            delivered = send_now;
         end else if (!delivered) begin
            // repeat of a waiting event: saturating duration sum
            sum           = {1'b0, held_duration} + {17'd0, dw};
            held_duration = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (send_now) begin
               made[n]   = held_token();
               n++;
               delivered = 1'b1;
            end
         end
      end
      if (n == 0) begin
         none.handled        = matched;
         none.token_valid    = 1'b0;
         none.digit          = '0;
         none.level          = '0;
         none.total_duration = '0;
         none.last           = 1'b1;
         beats_q.push_back(none);
      end else begin
         for (i = 0; i < n; i++) begin
            made[i].last = (i == n - 1);
            beats_q.push_back(made[i]);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         errors++;
      end
   endtask

   // sample every port at the edge, before the block updates
   always @(posedge clock) begin : monitor
      dtmf_beat_type want;
      if (reset) begin
         event_pt      = EVENT_PT_RESET;
         alt_pt        = ALT_PT_RESET;
         key_down_mode = 1'b0;
         have_event    = 1'b0;
         held_digit    = '0;
         held_level    = '0;
         held_stamp    = '0;
         held_duration = '0;
         delivered     = 1'b0;
         beats_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_EVENT_PT: event_pt      = csr_wdata;
               CSR_ALT_PT:   alt_pt        = csr_wdata;
               CSR_KEY_DOWN: key_down_mode = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_push && !req_full)
            predict_packet(req_payload_type, req_rtp_timestamp, req_event_word,
                           req_duration_word);
         if (rsp_pop && !rsp_empty) begin
            if (beats_q.size() == 0) begin
               $error("result beat popped with nothing due");
               errors++;
            end else begin
               want = beats_q.pop_front();
               check_field("handled", 32'(want.handled), 32'(rsp_handled));
               check_field("token_valid", 32'(want.token_valid), 32'(rsp_token_valid));
               check_field("digit", 32'(want.digit), 32'(rsp_digit));
               check_field("level", 32'(want.level), 32'(rsp_level));
               check_field("total_duration", want.total_duration, rsp_total_duration);
               check_field("last", 32'(want.last), 32'(rsp_last));
               checked++;
               if (want.token_valid)
                  tokens++;
            end
         end
      end
      fail_count     <= errors;
      beats_due      <= beats_q.size();
      beats_checked  <= checked;
      tokens_checked <= tokens;
   end

endmodule

// ===== dv/tb_rtp_dtmf_event_receiver_core.sv =====
// ----------------------------------------------------------------------------
// tb_rtp_dtmf_event_receiver_core
// Drives RTP telephone-event packets into the receiver core and gives the
// verdict. A directed pass covers foreign and quiet packets, held, flushed,
// repeated and released events and key-down delivery; random tone bursts with
// noise follow under nine register settings and three idling patterns, with a
// long result hold-off.
// Checking is done by the attached checker.
// ----------------------------------------------------------------------------
module tb_rtp_dtmf_event_receiver_core;
   import rtpdtmf_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 200;
   localparam int BLOCK_ITEMS = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [6:0]  req_payload_type = '0;
   logic [31:0] req_rtp_timestamp = '0;
   logic [15:0] req_event_word = '0;
   logic [15:0] req_duration_word = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_handled;
   logic        rsp_token_valid;
   logic [7:0]  rsp_digit;
   logic [5:0]  rsp_level;
   logic [31:0] rsp_total_duration;
   logic        rsp_last;

   int fail_count;
   int beats_due;
   int beats_checked;
   int tokens_checked;

   // stimulus bookkeeping
   int          packets_sent;
   int          tx_idle_pct;
   int          rx_idle_pct = 0;
   int          hold_requests = 0;
   int          hold_served;
   int          hold_left;
   int          stall_cycles;
   logic [6:0]  ev_pt = EVENT_PT_RESET;
   logic [6:0]  alt_pt = ALT_PT_RESET;
   logic [7:0]  prev_code;
   logic [31:0] prev_stamp;

   rtp_dtmf_event_receiver_core u_top (.*);

   rtp_dtmf_event_checker u_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // result side: random pops, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // watchdog on cycles with no beat moving on either channel
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[rtp_dtmf_event_receiver_core] ERROR");
         $finish;
      end
   end

   function automatic logic [15:0] tone_word(input logic [7:0] code, input logic end_bit,
                                             input logic [5:0] vol);
      return {code, end_bit, 1'b0, vol};
   endfunction

   // offer one packet and hold it until the block takes it
   task automatic send_packet(input logic [6:0] pt, input logic [31:0] stamp,
                              input logic [15:0] ew, input logic [15:0] dw);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push          <= 1'b1;
      req_payload_type  <= pt;
      req_rtp_timestamp <= stamp;
      req_event_word    <= ew;
      req_duration_word <= dw;
      do @(posedge clock); while (req_full);
      packets_sent++;
   endtask

   // stop offering and wait until every due beat has been popped
   task automatic drain();
      req_push <= 1'b0;
      do @(posedge clock); while (beats_due != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [6:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // registers change only with the block idle
   task automatic configure(input logic [6:0] ev, input logic [6:0] alt,
                            input logic [6:0] kd_word);
      drain();
      write_reg(CSR_EVENT_PT, ev);
      write_reg(CSR_ALT_PT, alt);
      write_reg(CSR_KEY_DOWN, kd_word);
      csr_we <= 1'b0;
      ev_pt  = ev;
      alt_pt = alt;
   endtask

   // well-formed event: one to six plain packets then zero to three with the end bit
   task automatic send_tone_burst();
      logic [7:0]  code;
      logic [31:0] stamp;
      logic [5:0]  vol;
      logic [5:0]  pkt_vol;
      logic [6:0]  pt;
      logic [15:0] step;
      int          repeats;
      int          enders;
      int          i;
      code  = ($urandom_range(3) != 0) ? 8'($urandom_range(15)) : 8'($urandom);
      stamp = $urandom;
      case ($urandom_range(5))
         0: stamp = prev_stamp;
         1: code  = prev_code;
         default: ;
      endcase
      vol     = 6'($urandom_range(55));
      repeats = $urandom_range(1, 6);
      enders  = $urandom_range(0, 3);
      step    = 16'($urandom_range(2000, 80));
      for (i = 0; i < repeats + enders; i++) begin
         pt      = $urandom_range(1) ? ev_pt : alt_pt;
         pkt_vol = ($urandom_range(7) == 0) ? 6'($urandom) : vol;
         send_packet(pt, stamp,
                     {code, 1'(i >= repeats), 1'($urandom), pkt_vol},
                     ($urandom_range(3) == 0) ? 16'($urandom) : step);
      end
      prev_code  = code;
      prev_stamp = stamp;
   endtask

   // noise: foreign types, random words, reused timestamps
   task automatic send_noise();
      logic [6:0]  pt;
      logic [31:0] stamp;
      pt    = $urandom_range(1) ? 7'($urandom) : ev_pt;
      stamp = $urandom_range(1) ? prev_stamp : $urandom;
      send_packet(pt, stamp, 16'($urandom), 16'($urandom));
   endtask

   initial begin : stimulus
      int          ph;
      int          blk;
      int          setting;
      int          block_end;
      logic [6:0]  ev;
      logic [6:0]  alt;
      packets_sent = 0;
      tx_idle_pct  = 0;
      prev_code    = '0;
      prev_stamp   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers, types 101, wait for end bit
      send_packet(7'd100, 32'hDEAD_BEEF, 16'hFFFF, 16'hFFFF);          // foreign type
      send_packet(7'd101, 32'h0, tone_word(8'd0, 1'b0, 6'd0), 16'h0);  // first event waits
      send_packet(7'd101, 32'h0, tone_word(8'd0, 1'b0, 6'd0), 16'hFFFF);
      send_packet(7'd101, 32'h0, tone_word(8'd0, 1'b1, 6'd55), 16'h0001); // end bit releases
      send_packet(7'd101, 32'h0, tone_word(8'd0, 1'b1, 6'd55), 16'h0010); // repeat, ignored
      send_packet(7'd101, 32'hFFFF_FFFF, tone_word(8'hFF, 1'b0, 6'd63), 16'h5); // too quiet
      send_packet(7'd101, 32'hFFFF_FFFF, tone_word(8'hFF, 1'b1, 6'd56), 16'h5);
      send_packet(7'd101, 32'hFFFF_FFFF, tone_word(8'hFF, 1'b0, 6'd55) | 16'h0040,
                  16'hFFFF);                                           // reserved bit set
      send_packet(7'd101, 32'h1, tone_word(8'd5, 1'b0, 6'd10), 16'h0100); // flush old
      send_packet(7'd101, 32'h1, tone_word(8'd6, 1'b1, 6'd12), 16'h0200); // flush plus new
      send_packet(7'd127, 32'h1, tone_word(8'd6, 1'b1, 6'd12), 16'h0200);
      send_packet(7'd0, 32'h2, tone_word(8'd7, 1'b1, 6'd0), 16'h0);

      // key-down delivery, extreme types
      configure(7'd0, 7'd127, 7'b1010101);
      send_packet(7'd0, 32'd100, tone_word(8'd3, 1'b0, 6'd20), 16'd160);
      send_packet(7'd127, 32'd100, tone_word(8'd3, 1'b0, 6'd20), 16'd160);
      send_packet(7'd127, 32'd200, 16'h03BF, 16'hFFFF);
      send_packet(7'd101, 32'd300, tone_word(8'd4, 1'b1, 6'd1), 16'd1);

      // held event released by a repeat in key-down mode
      configure(7'd0, 7'd127, 7'b1111110);
      send_packet(7'd0, 32'd400, tone_word(8'd9, 1'b0, 6'd30), 16'd320);
      configure(7'd0, 7'd127, 7'b0000001);
      send_packet(7'd127, 32'd400, tone_word(8'd9, 1'b0, 6'd30), 16'd320);

      // random bursts: three idling patterns, three settings each
      for (ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 57 : 0;
         rx_idle_pct <= (ph == 0) ? 57 : (ph == 1) ? 16 : 0;
         for (blk = 0; blk < 3; blk++) begin
            setting = ph * 3 + blk;
            case (setting % 4)
               0: begin ev = 7'd0;        alt = 7'd127;      end
               1: begin ev = 7'd127;      alt = 7'd127;      end
               2: begin ev = 7'($urandom); alt = 7'($urandom); end
               default: begin ev = 7'd101; alt = 7'd0;      end
            endcase
            configure(ev, alt, {6'($urandom), 1'(setting % 2)});
            // long result hold-off while packets keep coming
            if (setting == 0)
               hold_requests <= hold_requests + 1;
            block_end = packets_sent + BLOCK_ITEMS;
            while (packets_sent < block_end) begin
               if ($urandom_range(4) == 0)
                  send_noise();
               else
                  send_tone_burst();
            end
         end
      end

      // let the pipeline settle, then judge
      drain();
      repeat (16) @(posedge clock);
      $display("Run covered %0d packets: directed cases, 9 register settings and three",
               packets_sent);
      $display("idling patterns with a long hold-off; %0d result beats checked, %0d tokens.",
               beats_checked, tokens_checked);
      if (fail_count == 0 && beats_due == 0)
         $display("[rtp_dtmf_event_receiver_core] OK");
      else
         $display("[rtp_dtmf_event_receiver_core] ERROR");
      $finish;
   end

endmodule
